// File: rtl/core/lzw_byte_compressor_assert.svh
// assertion macros used by the port checker
`ifndef LZW_BYTE_COMPRESSOR_ASSERT_SVH
`define LZW_BYTE_COMPRESSOR_ASSERT_SVH

// checked from the cycle after a qualifying edge, skipped while in reset
`define LZWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzwc assertion failed");

// checked on every edge, reset included
`define LZWC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lzwc assertion failed");

`endif

// File: rtl/core/lzwc_pkg.sv
// ----------------------------------------------------------------------------
// lzwc_pkg
// shared types and constants of the lzw byte compressor
// ----------------------------------------------------------------------------
`default_nettype none

package lzwc_pkg;

    localparam int BYTE_W         = 8;
    localparam int CODE_OUT_W     = 16;
    localparam int FIRST_FREE     = 256;
    localparam int EPOCH_W        = 8;
    localparam int MAX_CODES_DEF  = 4096;
    localparam int HASH_SLOTS_DEF = 8192;
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    typedef struct packed {
        logic              stream_end;
        logic [BYTE_W-1:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic              final_code;
        logic [BYTE_W-1:0] code_high;
        logic [BYTE_W-1:0] code_low;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/lzw_byte_compressor.sv
// ----------------------------------------------------------------------------
// lzw_byte_compressor
// lzw compressor, one byte in, fixed 16-bit codes out
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                      | tlast
//  s_       | in  | [7:0] data_byte            | stream_end
//  m_       | out | [7:0] code_low [15:8] high | final_code
//
// steps: an item on a first-probe hit passes take, hash, read, compare and
//   finish; each extra probe of the hash chain repeats read and compare, an
//   emitted code adds an emit step, and a byte on an empty prefix goes from
//   take straight to finish
// reset: a clearing pass over all HASH_SLOTS slots runs after reset and after
//   every 255th stream; s_tready stays low during it
// stalls: a two-entry queue on each side decouples input and output
`default_nettype none

module lzw_byte_compressor #(
    parameter int MAX_CODES  = lzwc_pkg::MAX_CODES_DEF,
    parameter int HASH_SLOTS = lzwc_pkg::HASH_SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // stream_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [7:0] code_low, [15:8] code_high
    output logic             m_tlast    // final_code
);
    import lzwc_pkg::*;

    localparam int IN_W  = $bits(in_item_t);
    localparam int OUT_W = $bits(out_item_t);

    in_item_t  s_item, q_item;
    out_item_t e_item, m_item;
    logic      in_full, in_empty, in_pop;
    logic      out_full, out_empty, out_push;
    logic      clearing;

    // front side: take a transaction into the input queue
    assign s_item.data_byte  = s_tdata;
    assign s_item.stream_end = s_tlast;
    assign s_tready          = !in_full && !clearing;

    lzwc_fifo #(.WIDTH(IN_W), .DEPTH(2)) u_in_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid && s_tready),
        .push_data (s_item),
        .full      (in_full),
        .pop       (in_pop),
        .pop_data  (q_item),
        .empty     (in_empty)
    );

    // back side: dictionary engine
    lzwc_engine #(.MAX_CODES(MAX_CODES), .HASH_SLOTS(HASH_SLOTS)) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (!in_empty),
        .in_item   (q_item),
        .in_pop    (in_pop),
        .out_ready (!out_full),
        .out_push  (out_push),
        .out_item  (e_item),
        .clearing  (clearing)
    );

    // result queue holds codes until the sink takes them
    lzwc_fifo #(.WIDTH(OUT_W), .DEPTH(2)) u_out_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (out_push),
        .push_data (e_item),
        .full      (out_full),
        .pop       (m_tvalid && m_tready),
        .pop_data  (m_item),
        .empty     (out_empty)
    );

    assign m_tvalid = !out_empty;
    assign m_tdata  = {m_item.code_high, m_item.code_low};
    assign m_tlast  = m_item.final_code;

endmodule

`default_nettype wire

// File: rtl/core/lzwc_fifo.sv
// ----------------------------------------------------------------------------
// lzwc_fifo
// small register queue between the stages
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_fifo #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lzwc_engine.sv
// ----------------------------------------------------------------------------
// lzwc_engine
// dictionary probe, insert and code emission for one byte at a time
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_engine #(
    parameter int MAX_CODES  = lzwc_pkg::MAX_CODES_DEF,
    parameter int HASH_SLOTS = lzwc_pkg::HASH_SLOTS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire lzwc_pkg::in_item_t  in_item,
    output logic                     in_pop,
    input  wire logic                out_ready,
    output logic                     out_push,
    output lzwc_pkg::out_item_t      out_item,
    output logic                     clearing
);
    import lzwc_pkg::*;

    localparam int CW = $clog2(MAX_CODES);
    localparam int NW = CW + 1;
    localparam int KW = CW + BYTE_W;
    localparam int HW = $clog2(HASH_SLOTS);
    localparam int PW = HW + 1;
    localparam int MW = EPOCH_W + KW + CW;
    localparam logic [HW-1:0] MULT_LO = HASH_MULT[HW-1:0];

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_HASH   = 7'b0000100,
        S_READ   = 7'b0001000,
        S_COMP   = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    logic [MW-1:0] slot_mem [HASH_SLOTS];

    state_t              state_reg, state_next;
    logic [CW-1:0]       prefix_reg, prefix_next;
    logic                present_reg, present_next;
    logic [NW-1:0]       next_free_reg, next_free_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic                last_reg, last_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [HW-1:0]       idx_reg, idx_next;
    logic [PW-1:0]       probes_reg, probes_next;
    logic [HW-1:0]       clr_addr_reg, clr_addr_next;
    logic [MW-1:0]       rd_data_reg;

    logic                wr_en;
    logic [HW-1:0]       wr_addr;
    logic [MW-1:0]       wr_data;
    logic [31:0]         key32;
    logic [2*HW-1:0]     prod;
    logic [EPOCH_W-1:0]  rd_epoch;
    logic [KW-1:0]       rd_key;
    logic [CW-1:0]       rd_code;
    logic [CODE_OUT_W-1:0] code_wide;

    assign key32     = 32'(key_reg);
    assign prod      = key32[HW-1:0] * MULT_LO;
    assign rd_epoch  = rd_data_reg[MW-1 -: EPOCH_W];
    assign rd_key    = rd_data_reg[CW +: KW];
    assign rd_code   = rd_data_reg[CW-1:0];
    assign code_wide = CODE_OUT_W'(prefix_reg);
    assign clearing  = (state_reg == S_CLEAR);

    always_comb begin
        state_next     = state_reg;
        prefix_next    = prefix_reg;
        present_next   = present_reg;
        next_free_next = next_free_reg;
        epoch_next     = epoch_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        probes_next    = probes_reg;
        clr_addr_next  = clr_addr_reg;
        in_pop         = 1'b0;
        out_push       = 1'b0;
        out_item       = '0;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = '0;
        case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                if (clr_addr_reg == HW'(HASH_SLOTS - 1)) begin
                    epoch_next = EPOCH_W'(1);
                    state_next = S_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    in_pop    = 1'b1;
                    byte_next = in_item.data_byte;
                    last_next = in_item.stream_end;
                    if (!present_reg) begin
                        prefix_next  = CW'(in_item.data_byte);
                        present_next = 1'b1;
                        state_next   = S_FINISH;
                    end else begin
                        key_next   = {prefix_reg, in_item.data_byte};
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                idx_next    = prod[HW-1:0];
                probes_next = '0;
                state_next  = S_READ;
            end
            S_READ: begin
                state_next = S_COMP;
            end
            S_COMP: begin
                if (rd_epoch != epoch_reg) begin
                    // free slot: insert unless the code space is used up
                    if (next_free_reg < NW'(MAX_CODES)) begin
                        wr_en          = 1'b1;
                        wr_data        = {epoch_reg, key_reg, next_free_reg[CW-1:0]};
                        next_free_next = next_free_reg + 1'b1;
                    end
                    state_next = S_EMIT;
                end else if (rd_key == key_reg) begin
                    prefix_next = rd_code;
                    state_next  = S_FINISH;
                end else if (probes_reg == PW'(HASH_SLOTS - 1)) begin
                    state_next = S_EMIT;
                end else begin
                    probes_next = probes_reg + 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    state_next  = S_READ;
                end
            end
            S_EMIT: begin
                if (out_ready) begin
                    out_push            = 1'b1;
                    out_item.code_low   = code_wide[BYTE_W-1:0];
                    out_item.code_high  = code_wide[CODE_OUT_W-1:BYTE_W];
                    out_item.final_code = 1'b0;
                    prefix_next         = CW'(byte_reg);
                    state_next          = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (out_ready) begin
                    out_push            = 1'b1;
                    out_item.code_low   = code_wide[BYTE_W-1:0];
                    out_item.code_high  = code_wide[CODE_OUT_W-1:BYTE_W];
                    out_item.final_code = 1'b1;
                    prefix_next         = '0;
                    present_next        = 1'b0;
                    next_free_next      = NW'(FIRST_FREE);
                    epoch_next          = epoch_reg + 1'b1;
                    if (epoch_reg == '1) begin
                        clr_addr_next = '0;
                        state_next    = S_CLEAR;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            prefix_reg    <= '0;
            present_reg   <= 1'b0;
            next_free_reg <= NW'(FIRST_FREE);
            epoch_reg     <= '0;
            clr_addr_reg  <= '0;
            probes_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            prefix_reg    <= prefix_next;
            present_reg   <= present_next;
            next_free_reg <= next_free_next;
            epoch_reg     <= epoch_next;
            clr_addr_reg  <= clr_addr_next;
            probes_reg    <= probes_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        key_reg  <= key_next;
        idx_reg  <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[idx_reg];
    end

endmodule

`default_nettype wire

// File: rtl/core/lzwc_checker.sv
// ----------------------------------------------------------------------------
// lzwc_checker
// port-level checks of the lzw byte compressor
// ----------------------------------------------------------------------------
`default_nettype none

`include "lzw_byte_compressor_assert.svh"

module lzwc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);
    // stalled result holds
    `LZWC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `LZWC_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
    // reset empties the result queue
    `LZWC_ASSERT_NEXT_ALWAYS(a_rst_out, aclk, !aresetn, !m_tvalid)
    // clearing pass starts after reset, so no input is taken
    `LZWC_ASSERT_NEXT_ALWAYS(a_rst_in, aclk, !aresetn, !s_tready)

endmodule

bind lzw_byte_compressor lzwc_checker u_lzwc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: test/lzw_byte_compressor_checker.sv
// ----------------------------------------------------------------------------
// lzw_byte_compressor_checker
// watches both channels, predicts the emitted codes and compares them
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_byte_compressor_checker #(
    parameter int MAX_CODES  = lzwc_pkg::MAX_CODES_DEF,
    parameter int HASH_SLOTS = lzwc_pkg::HASH_SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               codes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted state of the compressor
    logic [11:0] cur_prefix;
    logic        have_prefix;
    logic [12:0] free_code;
    bit          slot_taken [HASH_SLOTS];
    logic [19:0] slot_pair  [HASH_SLOTS];
    logic [11:0] slot_value [HASH_SLOTS];

    lzwc_pkg::out_item_t code_queue[$];

    assign codes_pending = code_queue.size();

    task automatic report(input string what);
        $display("error: %s at %0t", what, $realtime);
        fail_count++;
    endtask

    function automatic void clear_dictionary();
        foreach (slot_taken[i]) slot_taken[i] = 1'b0;
        cur_prefix  = '0;
        have_prefix = 1'b0;
        free_code   = 13'd256;
    endfunction

    function automatic void push_code(input logic [11:0] code, input logic fin);
        lzwc_pkg::out_item_t item;
        item.code_low   = code[7:0];
        item.code_high  = {4'h0, code[11:8]};
        item.final_code = fin;
        code_queue.push_back(item);
    endfunction

    function automatic void compress_byte(input logic [7:0] data, input logic last);
        logic [19:0] pair;
        logic [31:0] prod;
        int          idx;
        int          spare;
        bit          found;
        logic [11:0] hit_code;
        pair  = {cur_prefix, data};
        spare = -1;
        found = 1'b0;
        if (!have_prefix) begin
            cur_prefix  = {4'h0, data};
            have_prefix = 1'b1;
        end else begin
            prod = {12'h0, pair} * lzwc_pkg::HASH_MULT;
            idx  = int'(prod % HASH_SLOTS);
            for (int n = 0; n < HASH_SLOTS; n++) begin
                if (!slot_taken[idx]) begin
                    spare = idx;
                    break;
                end
                if (slot_pair[idx] == pair) begin
                    found    = 1'b1;
                    hit_code = slot_value[idx];
                    break;
                end
                idx = (idx + 1) % HASH_SLOTS;
            end
            if (found) begin
                cur_prefix = hit_code;
            end else begin
                push_code(cur_prefix, 1'b0);
                // entries stop once the code space or the table runs out
                if (free_code < MAX_CODES && spare >= 0) begin
                    slot_taken[spare] = 1'b1;
                    slot_pair[spare]  = pair;
                    slot_value[spare] = free_code[11:0];
                    free_code++;
                end
                cur_prefix = {4'h0, data};
            end
        end
        if (last) begin
            push_code(cur_prefix, 1'b1);
            clear_dictionary();
        end
    endfunction

    initial begin
        fail_count = 0;
        clear_dictionary();
    end

    always @(posedge aclk) begin
        lzwc_pkg::out_item_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                compress_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (code_queue.size() == 0) begin
                    report($sformatf("unexpected code %h", m_tdata));
                end else begin
                    want = code_queue.pop_front();
                    if (m_tdata[7:0] != want.code_low)
                        report($sformatf("code_low %h, want %h", m_tdata[7:0],
                                         want.code_low));
                    if (m_tdata[15:8] != want.code_high)
                        report($sformatf("code_high %h, want %h", m_tdata[15:8],
                                         want.code_high));
                    if (m_tlast != want.final_code)
                        report($sformatf("final_code %b, want %b", m_tlast,
                                         want.final_code));
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// random and directed byte streams into the lzw compressor, codes checked
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          codes_pending;
    int          cycle_count;
    bit          stall_free;

    lzw_byte_compressor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .s_tlast  (s_tlast),   // stream_end
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] code_low, [15:8] code_high
        .m_tlast  (m_tlast)    // final_code
    );

    lzw_byte_compressor_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .codes_pending (codes_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog, sized for the clearing pass and slow stalls
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("lzw_byte_compressor: mismatch");
                $finish;
            end
        end
    end

    // short gaps mostly, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // receiver back-pressure, switched off in some stretches
    initial begin
        int hold;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!stall_free) hold = gap_length();
            end
        end
    end

    // one transaction on the input channel, a gap first
    task automatic send_byte(input logic [7:0] data, input logic last);
        int idle;
        idle = stall_free ? 0 : gap_length();
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // one edge first so the checker has taken the last transaction
    task automatic drain_codes();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (codes_pending != 0) @(posedge aclk);
    endtask

    // a stream of n bytes drawn from a small or a full alphabet
    task automatic send_stream(input int n, input int alpha);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, alpha)), i == n - 1);
    endtask

    initial begin
        int sent;
        int n;
        stall_free = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-byte stream: empty prefix flushed straight away
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        // repeats give hits; the last byte is a miss in the first two streams, a hit in the third
        send_byte(8'haa, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'haa, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        drain_codes();

        // random streams; once past 300 bytes the sender is held until every code has come
        sent = 15;
        while (sent < 650) begin
            n = $urandom_range(0, 7) == 0 ? $urandom_range(40, 120)
                                          : $urandom_range(1, 20);
            stall_free = $urandom_range(0, 5) == 0;
            send_stream(n, $urandom_range(0, 1) ? 255 : 3);
            sent += n;
            if (sent > 300 && sent - n <= 300) drain_codes();
        end
        stall_free = 1'b0;
        drain_codes();
        repeat (50) @(posedge aclk);

        // every predicted code must have come out
        if (fail_count == 0 && codes_pending == 0) begin
            $display("lzw_byte_compressor: match");
        end else begin
            $display("lzw_byte_compressor: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
